// ===== rtl/osa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osa_pkg
// Shared constants, request codes and controller/datapath handshake types for
// the optimal string alignment distance unit.
// ----------------------------------------------------------------------------
package osa_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int REQ_W       = 2;
  localparam int CHAR_W      = 8;
  localparam int DIST_W      = 7;
  localparam int DIST_MAX    = 127;

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ROW    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;

  typedef struct packed {
    logic col_write;
    logic row_overflow;
    logic row_start;
    logic issue;
    logic commit;
    logic finish;
  } osa_cmd_t;

  typedef struct packed {
    logic row_full;
    logic col_empty;
    logic scan_last;
  } osa_stat_t;

endpackage

`default_nettype wire

// ===== rtl/osa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osa_ctrl
// Sequencer: decodes requests, steps the datapath through one matrix row per
// string B byte and holds the result valid flag.
// ----------------------------------------------------------------------------
module osa_ctrl
  import osa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  input  wire logic [REQ_W-1:0] req_type,
  output logic                  req_stall,
  output logic                  res_valid,
  input  wire logic             res_stall,
  input  wire osa_stat_t        stat,
  output osa_cmd_t              cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_stall = (state != S_IDLE) || (res_valid && (req_type == REQ_FINISH));
  assign accept    = req_valid && !req_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_APPEND: cmd.col_write = 1'b1;
            REQ_ROW: begin
              if (stat.row_full) begin
                cmd.row_overflow = 1'b1;
              end else begin
                cmd.row_start = 1'b1;
                state_next    = stat.col_empty ? S_DRAIN : S_SCAN;
              end
            end
            REQ_FINISH: cmd.finish = 1'b1;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(cmd.finish))
    else $error("result raised without a finish item");

  a_scan_needs_columns: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !stat.col_empty)
    else $error("row scan with empty string A");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !res_valid)
    else $error("finish while previous result still pending");

endmodule

`default_nettype wire

// ===== rtl/osa_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osa_datapath
// Column store, three rotating row banks and the single cell evaluator of the
// dynamic-programming matrix; one cell per cycle behind a registered read.
// ----------------------------------------------------------------------------
module osa_datapath
  import osa_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire osa_cmd_t          cmd,
  input  wire logic [CHAR_W-1:0] char_in,
  output osa_stat_t              stat,
  output logic [DIST_W-1:0]      distance,
  output logic                   overflow
);

  localparam int AW    = $clog2(MAX_LEN);
  localparam int CW    = $clog2(MAX_LEN + 1);
  localparam int DEPTH = MAX_LEN + 1;
  localparam int OW    = (CW > DIST_W) ? CW : DIST_W;

  function automatic logic [1:0] next_bank(input logic [1:0] b);
    next_bank = (b == 2'd2) ? 2'd0 : b + 2'd1;
  endfunction

  logic [CHAR_W-1:0] col_mem [MAX_LEN];
  logic [CW-1:0]     row_mem [3][DEPTH];
  logic [CW-1:0]     bank_rd [3];

  logic [CW-1:0]     column_count;
  logic [CW-1:0]     row_count;
  logic [CHAR_W-1:0] last_ch;
  logic              overflow_seen;
  logic [1:0]        prev_sel;
  logic              cmp_valid;

  logic [CW-1:0]     j;
  logic [CW-1:0]     cmp_j;
  logic [CHAR_W-1:0] row_ch;
  logic [CHAR_W-1:0] col_rd;
  logic [CHAR_W-1:0] colc_prev;
  logic [CW-1:0]     cur_jm1;
  logic [CW-1:0]     prev_jm1;
  logic [CW-1:0]     final_dist;

  logic [1:0]        new_sel;
  logic [1:0]        older_sel;
  logic              col_full;
  logic              col_we;
  logic [CW-1:0]     j_m1;
  logic [CW-1:0]     older_addr;
  logic [CW-1:0]     row_val;
  logic              wr_en;
  logic [CW-1:0]     wr_addr;
  logic [CW-1:0]     wr_data;

  logic [CW-1:0]     prev_j;
  logic [CW-1:0]     older_v;
  logic [CW:0]       c_del;
  logic [CW:0]       c_ins;
  logic [CW:0]       c_sub;
  logic [CW:0]       c_tra;
  logic [CW:0]       m_a;
  logic [CW:0]       m_b;
  logic [CW:0]       m_c;
  logic              trans_ok;
  logic [CW-1:0]     best;

  logic [CW-1:0]     dist_base;
  logic [OW-1:0]     dist_ext;

  assign new_sel    = next_bank(prev_sel);
  assign older_sel  = next_bank(new_sel);
  assign col_full   = (column_count == CW'(MAX_LEN));
  assign col_we     = cmd.col_write && (row_count == '0) && !col_full;
  assign j_m1       = j - CW'(1);
  assign older_addr = (j > CW'(1)) ? j - CW'(2) : '0;
  assign row_val    = row_count + CW'(1);

  assign stat.row_full  = (row_count == CW'(MAX_LEN));
  assign stat.col_empty = (column_count == '0);
  assign stat.scan_last = (j == column_count);

  // cell evaluation; first row and the row before it are the index ramp
  assign prev_j  = (row_count == '0) ? cmp_j : bank_rd[prev_sel];
  assign older_v = (row_count == CW'(1)) ? cmp_j - CW'(2) : bank_rd[older_sel];

  assign c_del = {1'b0, prev_j} + (CW+1)'(1);
  assign c_ins = {1'b0, cur_jm1} + (CW+1)'(1);
  assign c_sub = {1'b0, prev_jm1} + (CW+1)'(col_rd != row_ch);
  assign c_tra = {1'b0, older_v} + (CW+1)'(1);

  assign trans_ok = (cmp_j > CW'(1)) && (row_count != '0)
                    && (col_rd == last_ch) && (colc_prev == row_ch);

  assign m_a  = (c_del < c_ins) ? c_del : c_ins;
  assign m_b  = (m_a < c_sub) ? m_a : c_sub;
  assign m_c  = (trans_ok && (c_tra < m_b)) ? c_tra : m_b;
  assign best = m_c[CW-1:0];

  assign wr_en   = cmd.row_start || cmp_valid;
  assign wr_addr = cmd.row_start ? '0 : cmp_j;
  assign wr_data = cmd.row_start ? row_val : best;

  assign dist_base = (row_count == '0) ? column_count : final_dist;
  assign dist_ext  = OW'(dist_base);

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[column_count[AW-1:0]] <= char_in;
    end
    if (cmd.issue) begin
      col_rd <= col_mem[j_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 3; b++) begin
      if (wr_en && (new_sel == 2'(b))) begin
        row_mem[b][wr_addr] <= wr_data;
      end
      if (cmd.issue) begin
        bank_rd[b] <= row_mem[b][(prev_sel == 2'(b)) ? j : older_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      last_ch       <= '0;
      overflow_seen <= 1'b0;
      prev_sel      <= 2'd0;
      cmp_valid     <= 1'b0;
    end else begin
      cmp_valid <= cmd.issue;
      if (col_we) begin
        column_count <= column_count + CW'(1);
      end
      if ((cmd.col_write && (row_count == '0) && col_full) || cmd.row_overflow) begin
        overflow_seen <= 1'b1;
      end
      if (cmd.commit) begin
        prev_sel  <= next_bank(prev_sel);
        row_count <= row_val;
        last_ch   <= row_ch;
      end
      if (cmd.finish) begin
        column_count  <= '0;
        row_count     <= '0;
        last_ch       <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_start) begin
      j          <= CW'(1);
      row_ch     <= char_in;
      cur_jm1    <= row_val;
      prev_jm1   <= row_count;
      final_dist <= row_val;
    end
    if (cmd.issue) begin
      j     <= j + CW'(1);
      cmp_j <= j;
    end
    if (cmp_valid) begin
      cur_jm1    <= best;
      prev_jm1   <= prev_j;
      colc_prev  <= col_rd;
      final_dist <= best;
    end
    if (cmd.finish) begin
      distance <= (dist_ext > OW'(DIST_MAX)) ? DIST_W'(DIST_MAX) : DIST_W'(dist_ext);
      overflow <= overflow_seen;
    end
  end

  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (j != '0) && (j <= column_count))
    else $error("cell index outside string A");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (row_count <= CW'(MAX_LEN)) && (column_count <= CW'(MAX_LEN)))
    else $error("string length beyond limit");

  a_cell_bounded: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (m_c <= (CW+1)'(MAX_LEN)))
    else $error("matrix cell beyond limit");

endmodule

`default_nettype wire

// ===== rtl/osa_edit_distance_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osa_edit_distance_unit
// Optimal string alignment (restricted Damerau-Levenshtein) distance between
// two byte strings, loaded one byte per item, result on a finish item.
//
//   channel  signals                        fields
//   req      req_valid / req_stall          req_type, char_in
//   res      res_valid / res_stall          distance, overflow
//
// a string B byte builds one matrix row, one matrix cell per cycle through the
// single read port of each row bank; append, finish and unused codes build none.
// synchronous reset; no memory clearing pass, the first row is generated.
// req_stall is high while a row is being built, and for a finish item while
// the previous result is still waiting on res_stall.
// ----------------------------------------------------------------------------
module osa_edit_distance_unit
  import osa_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire logic [REQ_W-1:0]  req_type,
  input  wire logic [CHAR_W-1:0] char_in,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output logic [DIST_W-1:0]      distance,
  output logic                   overflow
);

  osa_cmd_t  cmd;
  osa_stat_t stat;

  osa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_type),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  osa_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .char_in  (char_in),
    .stat     (stat),
    .distance (distance),
    .overflow (overflow)
  );

endmodule

`default_nettype wire

// ===== sim/osa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osa_checker
// Watches both channels of the edit distance unit, keeps its own copy of the
// string store and the last two matrix rows, predicts the distance and the
// truncation flag for each finish item and compares them with the results.
// ----------------------------------------------------------------------------
module osa_checker
  import osa_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire logic              req_stall,
  input  wire logic [REQ_W-1:0]  req_type,
  input  wire logic [CHAR_W-1:0] char_in,
  input  wire logic              res_valid,
  input  wire logic              res_stall,
  input  wire logic [DIST_W-1:0] distance,
  input  wire logic              overflow,
  output int                     fail_count,
  output int                     pending_count
);

  typedef struct packed {
    logic [DIST_W-1:0] dist_val;
    logic              trunc;
  } dist_pair_t;

  dist_pair_t        pending_dist[$];
  dist_pair_t        want;

  logic [CHAR_W-1:0] a_bytes[MAX_LEN];
  int                a_len;
  int                b_len;
  int                row_now[MAX_LEN+1];
  int                row_prev[MAX_LEN+1];
  int                row_old[MAX_LEN+1];
  logic [CHAR_W-1:0] b_last;
  bit                trunc_seen;

  function automatic void clear_pair();
    a_len      = 0;
    b_len      = 0;
    b_last     = '0;
    trunc_seen = 1'b0;
    for (int k = 0; k <= MAX_LEN; k++) row_prev[k] = k;
  endfunction

  task automatic absorb_item(input logic [REQ_W-1:0] kind, input logic [CHAR_W-1:0] ch);
    int         best;
    int         sub;
    dist_pair_t res;
    case (kind)
      REQ_APPEND: begin
        if (b_len == 0) begin
          if (a_len >= MAX_LEN) begin
            trunc_seen = 1'b1;
          end else begin
            a_bytes[a_len] = ch;
            a_len++;
          end
        end
      end
      REQ_ROW: begin
        if (b_len >= MAX_LEN) begin
          trunc_seen = 1'b1;
        end else begin
          row_now[0] = b_len + 1;
          for (int j = 1; j <= a_len; j++) begin
            best = row_prev[j] + 1;
            if (row_now[j-1] + 1 < best) best = row_now[j-1] + 1;
            sub = row_prev[j-1] + ((a_bytes[j-1] == ch) ? 0 : 1);
            if (sub < best) best = sub;
            // adjacent transposition
            if (b_len > 0 && j > 1 && a_bytes[j-1] == b_last && a_bytes[j-2] == ch &&
                row_old[j-2] + 1 < best)
              best = row_old[j-2] + 1;
            row_now[j] = best;
          end
          row_old  = row_prev;
          row_prev = row_now;
          b_last   = ch;
          b_len++;
        end
      end
      REQ_FINISH: begin
        best         = (row_prev[a_len] > DIST_MAX) ? DIST_MAX : row_prev[a_len];
        res.dist_val = best[DIST_W-1:0];
        res.trunc    = trunc_seen;
        pending_dist.push_back(res);
        clear_pair();
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_pair();
      pending_dist.delete();
      fail_count = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (pending_dist.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, distance %0d overflow %0b",
                   $time, distance, overflow);
        end else begin
          want = pending_dist.pop_front();
          if (distance !== want.dist_val) begin
            fail_count++;
            $display("%0t: distance expected %0d actual %0d", $time, want.dist_val, distance);
          end
          if (overflow !== want.trunc) begin
            fail_count++;
            $display("%0t: overflow expected %0b actual %0b", $time, want.trunc, overflow);
          end
        end
      end
      if (req_valid && !req_stall) absorb_item(req_type, char_in);
    end
    pending_count = pending_dist.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives string pairs into the edit distance unit: a few hand-picked pairs,
// then random pairs of mostly short, often related strings with stray items
// mixed in, under random idling and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import osa_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_in;
  logic              res_valid;
  logic              res_stall;
  logic [DIST_W-1:0] distance;
  logic              overflow;
  int                fail_count;
  int                pending_count;

  int                n_sent;
  bit                calm;
  bit                hold_go;

  osa_edit_distance_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .char_in   (char_in),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .distance  (distance),
    .overflow  (overflow)
  );

  osa_checker chk (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_type      (req_type),
    .char_in       (char_in),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .distance      (distance),
    .overflow      (overflow),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic send(input logic [REQ_W-1:0] kind, input logic [CHAR_W-1:0] ch);
    while (!calm && $urandom_range(0, 99) < 29) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= kind;
    char_in   <= ch;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    n_sent++;
    if (n_sent == 120) hold_go = 1'b1;
    calm = (n_sent >= 250 && n_sent < 370);
  endtask

  function automatic int pick_len(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 1) return $urandom_range(64, 66);
    if (r < 3) return $urandom_range(60, 66);
    if (r < 20) return $urandom_range(9, 20);
    return $urandom_range(0, 8);
  endfunction

  task automatic run_pair(input int mode);
    int                la;
    int                lb;
    int                p;
    bit                narrow;
    logic [CHAR_W-1:0] alpha[4];
    logic [CHAR_W-1:0] sa[$];
    logic [CHAR_W-1:0] sb[$];
    logic [CHAR_W-1:0] tmp;
    la     = pick_len(mode);
    lb     = pick_len(mode);
    narrow = 1'($urandom_range(0, 1));
    for (int k = 0; k < 4; k++) alpha[k] = CHAR_W'($urandom_range(0, 255));
    for (int k = 0; k < la; k++)
      sa.push_back(narrow ? alpha[$urandom_range(0, 3)] : CHAR_W'($urandom_range(0, 255)));
    if (mode == 0 && $urandom_range(0, 1)) begin
      // string b as a lightly edited copy of string a
      sb = sa;
      repeat ($urandom_range(0, 3)) begin
        if (sb.size() > 1) begin
          p = $urandom_range(0, sb.size() - 2);
          case ($urandom_range(0, 4))
            0, 1: begin
              tmp     = sb[p];
              sb[p]   = sb[p+1];
              sb[p+1] = tmp;
            end
            2: sb[p] = narrow ? alpha[$urandom_range(0, 3)] : CHAR_W'($urandom_range(0, 255));
            3: sb.delete(p);
            default: sb.insert(p, CHAR_W'($urandom_range(0, 255)));
          endcase
        end
      end
    end else begin
      for (int k = 0; k < lb; k++)
        sb.push_back(narrow ? alpha[$urandom_range(0, 3)] : CHAR_W'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 19) == 0) send(REQ_UNUSED, CHAR_W'($urandom_range(0, 255)));
    for (int k = 0; k < sa.size(); k++) send(REQ_APPEND, sa[k]);
    for (int k = 0; k < sb.size(); k++) begin
      send(REQ_ROW, sb[k]);
      if ($urandom_range(0, 19) == 0)
        send($urandom_range(0, 1) ? REQ_APPEND : REQ_UNUSED, CHAR_W'($urandom_range(0, 255)));
    end
    send(REQ_FINISH, CHAR_W'($urandom_range(0, 255)));
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= !calm && $urandom_range(0, 99) < 29;
      end
    end
  end

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req_type  = REQ_APPEND;
    char_in   = '0;
    res_stall = 1'b0;
    n_sent    = 0;
    calm      = 1'b0;
    hold_go   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // both strings empty
    send(REQ_FINISH, 8'h00);
    // b empty
    send(REQ_APPEND, 8'h00);
    send(REQ_APPEND, 8'hff);
    send(REQ_FINISH, 8'hff);
    // a empty
    send(REQ_ROW, 8'hff);
    send(REQ_ROW, 8'h00);
    send(REQ_FINISH, 8'h00);
    // transposition, with a late append and an unused code in between
    send(REQ_APPEND, 8'h61);
    send(REQ_APPEND, 8'h62);
    send(REQ_ROW, 8'h62);
    send(REQ_APPEND, 8'h55);
    send(REQ_UNUSED, 8'haa);
    send(REQ_ROW, 8'h61);
    send(REQ_FINISH, 8'h00);
    // "ca" against "abc"
    send(REQ_APPEND, 8'h63);
    send(REQ_APPEND, 8'h61);
    send(REQ_ROW, 8'h61);
    send(REQ_ROW, 8'h62);
    send(REQ_ROW, 8'h63);
    send(REQ_FINISH, 8'h00);

    // both strings at or past the limit
    run_pair(1);
    run_pair(1);
    while (n_sent < 550) run_pair(0);
    req_valid <= 1'b0;

    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== osa_edit_distance_unit.f =====
rtl/osa_pkg.sv
rtl/osa_ctrl.sv
rtl/osa_datapath.sv
rtl/osa_edit_distance_unit.sv
sim/osa_checker.sv
sim/tb_top.sv
